FILE: design/cc2p_pkg.sv
// ----------------------------------------------------------------------------
// cc2p_pkg
// Types and constants shared by the cartesian-to-polar CORDIC pipeline.
// ----------------------------------------------------------------------------
package cc2p_pkg;

    localparam int unsigned W_IN  = 16;
    localparam int unsigned W_XY  = 20;
    localparam int unsigned W_Z   = 12;
    localparam int unsigned W_ANG = 12;
    localparam int unsigned W_MAG = 16;
    localparam int unsigned W_PRD = W_XY + 17;

    localparam logic signed [W_Z-1:0] HALF_TURN     = 12'sd1800;
    localparam logic signed [W_Z:0]   HALF_TURN_X   = 13'sd1800;
    localparam logic signed [W_Z:0]   FULL_TURN_X   = 13'sd3600;
    localparam logic signed [16:0]    INV_GAIN_Q16  = 17'sd39797;

    localparam logic signed [W_Z-1:0] ATAN_TENTHS [16] = '{
        12'sd450, 12'sd265, 12'sd140, 12'sd71, 12'sd36, 12'sd18, 12'sd9, 12'sd4,
        12'sd2,   12'sd1,   12'sd1,   12'sd0,  12'sd0,  12'sd0,  12'sd0, 12'sd0
    };

    typedef struct packed {
        logic signed [W_IN-1:0] x_coord;
        logic signed [W_IN-1:0] y_coord;
    } t_in;

    typedef struct packed {
        logic [W_MAG-1:0]        magnitude;
        logic signed [W_ANG-1:0] angle_tenths;
    } t_out;

    typedef struct packed {
        logic signed [W_XY-1:0] x;
        logic signed [W_XY-1:0] y;
        logic signed [W_Z-1:0]  z;
        logic signed [W_Z-1:0]  offset;
    } t_rot;

endpackage

FILE: design/cc2p_prerot.sv
// ----------------------------------------------------------------------------
// cc2p_prerot
// Entry stage: mirror left-half-plane vectors and note the half-turn offset.
// ----------------------------------------------------------------------------
module cc2p_prerot (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cc2p_pkg::t_in   i_data,
    input  logic            i_ready_next,
    output logic            o_ready,
    output logic            o_valid,
    output cc2p_pkg::t_rot  o_data
);

    logic            r_valid;
    cc2p_pkg::t_rot  r_data;
    cc2p_pkg::t_rot  n_data;
    logic signed [cc2p_pkg::W_XY-1:0] x_ext;
    logic signed [cc2p_pkg::W_XY-1:0] y_ext;

    assign o_ready = !r_valid || i_ready_next;

    always_comb begin
        x_ext = cc2p_pkg::W_XY'(i_data.x_coord);
        y_ext = cc2p_pkg::W_XY'(i_data.y_coord);
        n_data.z = '0;
        if (x_ext[cc2p_pkg::W_XY-1]) begin
            n_data.x      = -x_ext;
            n_data.y      = -y_ext;
            n_data.offset = y_ext[cc2p_pkg::W_XY-1] ? -cc2p_pkg::HALF_TURN
                                                    : cc2p_pkg::HALF_TURN;
        end else begin
            n_data.x      = x_ext;
            n_data.y      = y_ext;
            n_data.offset = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: design/cc2p_stage.sv
// ----------------------------------------------------------------------------
// cc2p_stage
// One registered CORDIC vectoring micro-rotation.
// ----------------------------------------------------------------------------
module cc2p_stage #(
    parameter int unsigned STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cc2p_pkg::t_rot  i_data,
    input  logic            i_ready_next,
    output logic            o_ready,
    output logic            o_valid,
    output cc2p_pkg::t_rot  o_data
);

    localparam logic signed [cc2p_pkg::W_Z-1:0] ATAN = cc2p_pkg::ATAN_TENTHS[4'(STEP)];

    logic            r_valid;
    cc2p_pkg::t_rot  r_data;
    cc2p_pkg::t_rot  n_data;
    logic signed [cc2p_pkg::W_XY-1:0] xs;
    logic signed [cc2p_pkg::W_XY-1:0] ys;

    assign o_ready = !r_valid || i_ready_next;

    always_comb begin
        xs = i_data.x >>> STEP;
        ys = i_data.y >>> STEP;
        n_data.offset = i_data.offset;
        if (i_data.y[cc2p_pkg::W_XY-1]) begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - ATAN;
        end else begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: design/cc2p_post.sv
// ----------------------------------------------------------------------------
// cc2p_post
// Gain correction and angle wrap: multiply stage, then saturate/wrap stage.
// ----------------------------------------------------------------------------
module cc2p_post (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cc2p_pkg::t_rot  i_data,
    input  logic            i_ready_next,
    output logic            o_ready,
    output logic            o_valid,
    output cc2p_pkg::t_out  o_data
);

    logic                                r_mul_valid;
    logic signed [cc2p_pkg::W_PRD-1:0]   r_prod;
    logic signed [cc2p_pkg::W_Z:0]       r_ang;
    logic signed [cc2p_pkg::W_PRD-1:0]   n_prod;
    logic signed [cc2p_pkg::W_Z:0]       n_ang;
    logic                                mul_ready;

    logic                                r_out_valid;
    cc2p_pkg::t_out                      r_out;
    cc2p_pkg::t_out                      n_out;
    logic signed [cc2p_pkg::W_PRD-17:0]  prod_hi;
    logic [cc2p_pkg::W_PRD-17:0]         dist_abs;
    logic signed [cc2p_pkg::W_Z:0]       ang_wrap;
    logic                                out_ready;

    assign out_ready = !r_out_valid || i_ready_next;
    assign mul_ready = !r_mul_valid || out_ready;
    assign o_ready   = mul_ready;

    always_comb begin
        n_prod = cc2p_pkg::W_PRD'(i_data.x) * cc2p_pkg::W_PRD'(cc2p_pkg::INV_GAIN_Q16);
        n_ang  = (cc2p_pkg::W_Z+1)'(i_data.z) + (cc2p_pkg::W_Z+1)'(i_data.offset);
    end

    always_comb begin
        prod_hi  = r_prod[cc2p_pkg::W_PRD-1:16];
        dist_abs = prod_hi[cc2p_pkg::W_PRD-17] ? (cc2p_pkg::W_PRD-16)'(-prod_hi)
                                               : (cc2p_pkg::W_PRD-16)'(prod_hi);
        if (|dist_abs[cc2p_pkg::W_PRD-17:cc2p_pkg::W_MAG]) begin
            n_out.magnitude = '1;
        end else begin
            n_out.magnitude = dist_abs[cc2p_pkg::W_MAG-1:0];
        end
        if (r_ang > cc2p_pkg::HALF_TURN_X) begin
            ang_wrap = r_ang - cc2p_pkg::FULL_TURN_X;
        end else if (r_ang < -cc2p_pkg::HALF_TURN_X) begin
            ang_wrap = r_ang + cc2p_pkg::FULL_TURN_X;
        end else begin
            ang_wrap = r_ang;
        end
        n_out.angle_tenths = ang_wrap[cc2p_pkg::W_ANG-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (mul_ready) begin
                r_mul_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_mul_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_ready && i_valid) begin
            r_prod <= n_prod;
            r_ang  <= n_ang;
        end
        if (out_ready && r_mul_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: design/cordic_cartesian_to_polar.sv
// ----------------------------------------------------------------------------
// cordic_cartesian_to_polar
// Pipelined CORDIC vectoring converter from (x, y) to (magnitude, angle).
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one (x_coord, y_coord) transaction,
// taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry one (magnitude, angle_tenths)
// transaction per input, in input order; angle is in tenths of a degree.
// Stages in order: one mirror stage, one register per micro-rotation,
// one multiply stage, one saturate/wrap stage. Throughput is one
// transaction per cycle while i_stall is low, set by the
// one-rotation-per-stage pipeline.
// Each stage loads whenever it is empty or its successor moves, so bubbles
// collapse; when i_stall is held the pipeline fills up and o_stall rises
// only once the entry stage holds data that cannot move.
// Reset (synchronous, active low) clears every stage valid bit; results in
// flight are dropped. Data registers are not reset.
// ----------------------------------------------------------------------------
module cordic_cartesian_to_polar #(
    parameter int unsigned ITERATIONS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  cc2p_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output cc2p_pkg::t_out  o_data
);

    logic [ITERATIONS:0]    s_valid;
    logic [ITERATIONS+1:0]  s_ready;
    cc2p_pkg::t_rot         s_data [ITERATIONS+1];

    cc2p_prerot u_prerot (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data       (i_data),
        .i_ready_next (s_ready[1]),
        .o_ready      (s_ready[0]),
        .o_valid      (s_valid[0]),
        .o_data       (s_data[0])
    );

    for (genvar k = 0; k < ITERATIONS; k++) begin : g_rot
        cc2p_stage #(
            .STEP (k)
        ) u_stage (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (s_valid[k]),
            .i_data       (s_data[k]),
            .i_ready_next (s_ready[k+2]),
            .o_ready      (s_ready[k+1]),
            .o_valid      (s_valid[k+1]),
            .o_data       (s_data[k+1])
        );
    end

    cc2p_post u_post (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_valid[ITERATIONS]),
        .i_data       (s_data[ITERATIONS]),
        .i_ready_next (!i_stall),
        .o_ready      (s_ready[ITERATIONS+1]),
        .o_valid      (o_valid),
        .o_data       (o_data)
    );

    assign o_stall = !s_ready[0];

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.angle_tenths <= 12'sd1800)
                 && (o_data.angle_tenths >= -12'sd1800))
        else $error("angle outside half-turn range");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> s_valid[0] && o_valid && i_stall)
        else $error("input stalled without a stalled, full pipeline");

    a_full_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |-> !o_stall)
        else $error("input stalled while output drains");

endmodule
